>>> rtl/ats_pkg.sv
package ats_pkg;

  // Width of the running byte offset; outputs carry its low 16 bits
  localparam int unsigned POS_W   = 16;
  // Width of the token offset, length and line fields
  localparam int unsigned FLD_W   = 16;
  localparam int unsigned MAX_TOK = 3;
  localparam int unsigned CNT_W   = $clog2(MAX_TOK + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_TOK);
  localparam logic [FLD_W-1:0] FLD_MAX = {FLD_W{1'b1}};

  // Character codes
  localparam logic [7:0] CH_EOT = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DOT = 8'h2E;

  // Keyword slots in the match vector
  localparam int unsigned KW_SET  = 0;
  localparam int unsigned KW_JUMP = 1;
  localparam int unsigned KW_MUL  = 2;
  localparam int unsigned KW_NUM  = 3;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [FLD_W-1:0] fld_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_INT     = 3'd1,
    MODE_INT_DOT = 3'd2,
    MODE_DEC     = 3'd3,
    MODE_WORD    = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    KIND_INT  = 3'd0,
    KIND_DEC  = 3'd1,
    KIND_SET  = 3'd2,
    KIND_JUMP = 3'd3,
    KIND_MUL  = 3'd4,
    KIND_ERR  = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e kind;
    fld_t  start;
    fld_t  length;
    fld_t  line;
  } tok_t;

  // Tokens caused by one byte, in output order, and how many are valid
  typedef struct packed {
    tok_t [MAX_TOK-1:0] tok;
    logic [CNT_W-1:0]   cnt;
  } tok_grp_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic fld_t kw_len(input int unsigned k);
    fld_t l;
    case (k)
      KW_JUMP: l = fld_t'(4);
      default: l = fld_t'(3);
    endcase
    return l;
  endfunction

  function automatic kind_e kw_kind(input int unsigned k);
    kind_e r;
    case (k)
      KW_SET:  r = KIND_SET;
      KW_JUMP: r = KIND_JUMP;
      default: r = KIND_MUL;
    endcase
    return r;
  endfunction

  // True when keyword k has character c at offset idx
  function automatic logic kw_char_ok(input int unsigned k, input fld_t idx,
                                      input logic [7:0] c);
    logic ok;
    case (k)
      KW_SET:  ok = (idx == fld_t'(0) && c == "s") || (idx == fld_t'(1) && c == "e") ||
                    (idx == fld_t'(2) && c == "t");
      KW_JUMP: ok = (idx == fld_t'(0) && c == "j") || (idx == fld_t'(1) && c == "u") ||
                    (idx == fld_t'(2) && c == "m") || (idx == fld_t'(3) && c == "p");
      default: ok = (idx == fld_t'(0) && c == "m") || (idx == fld_t'(1) && c == "u") ||
                    (idx == fld_t'(2) && c == "l");
    endcase
    return ok;
  endfunction

  function automatic fld_t sat_add(input fld_t a, input logic [1:0] b);
    logic [FLD_W:0] s;
    s = {1'b0, a} + {{(FLD_W-1){1'b0}}, b};
    return s[FLD_W] ? FLD_MAX : s[FLD_W-1:0];
  endfunction

  function automatic tok_t mk_tok(input kind_e kind, input pos_t start, input fld_t len,
                                  input fld_t line);
    tok_t t;
    t.kind   = kind;
    t.start  = fld_t'(start);
    t.length = len;
    t.line   = line;
    return t;
  endfunction

endpackage

>>> rtl/ats_scan.sv
module ats_scan
  import ats_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] ch_i,
  input  logic       adv_i,
  output tok_grp_t   grp_o
);

  mode_e        mode_q, mode_d;
  pos_t         pos_q, pos_d;
  pos_t         start_q, start_d;
  fld_t         len_q, len_d;
  fld_t         line_q, line_d;
  logic [KW_NUM-1:0] kw_q, kw_d;

  // Next scanner state and the tokens this byte produces
  always_comb begin
    logic             consumed;
    logic [CNT_W-1:0] n;
    kind_e            wkind;
    logic [KW_NUM-1:0] kw_trk;

    mode_d   = mode_q;
    pos_d    = pos_q;
    start_d  = start_q;
    len_d    = len_q;
    line_d   = line_q;
    kw_d     = kw_q;
    consumed = 1'b0;
    n        = '0;
    wkind    = KIND_ERR;
    for (int i = 0; i < MAX_TOK; i++) begin
      grp_o.tok[i] = mk_tok(KIND_INT, '0, '0, '0);
    end

    // Keyword tracking against the current character offset
    for (int unsigned k = 0; k < KW_NUM; k++) begin
      kw_trk[k] = kw_q[k] && (len_q < kw_len(k)) && kw_char_ok(k, len_q, ch_i);
    end
    for (int unsigned k = 0; k < KW_NUM; k++) begin
      if (kw_q[k] && len_q == kw_len(k)) wkind = kw_kind(k);
    end

    // Extend the lexeme in progress
    case (mode_q)
      MODE_INT: begin
        if (is_digit(ch_i)) begin
          len_d    = sat_add(len_q, 2'd1);
          consumed = 1'b1;
        end else if (ch_i == CH_DOT) begin
          mode_d   = MODE_INT_DOT;
          consumed = 1'b1;
        end
      end
      MODE_INT_DOT: begin
        if (is_digit(ch_i)) begin
          mode_d   = MODE_DEC;
          len_d    = sat_add(len_q, 2'd2);
          consumed = 1'b1;
        end
      end
      MODE_DEC: begin
        if (is_digit(ch_i)) begin
          len_d    = sat_add(len_q, 2'd1);
          consumed = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_digit(ch_i) || is_letter(ch_i)) begin
          kw_d     = kw_trk;
          len_d    = sat_add(len_q, 2'd1);
          consumed = 1'b1;
        end
      end
      default: ;
    endcase

    if (!consumed) begin
      // Close out the pending lexeme
      case (mode_q)
        MODE_INT: begin
          grp_o.tok[0] = mk_tok(KIND_INT, start_q, len_q, line_q);
          n = CNT_W'(1);
        end
        MODE_INT_DOT: begin
          grp_o.tok[0] = mk_tok(KIND_INT, start_q, len_q, line_q);
          grp_o.tok[1] = mk_tok(KIND_ERR, pos_t'(start_q + pos_t'(len_q)),
                                fld_t'(1), line_q);
          n = CNT_W'(2);
        end
        MODE_DEC: begin
          grp_o.tok[0] = mk_tok(KIND_DEC, start_q, len_q, line_q);
          n = CNT_W'(1);
        end
        MODE_WORD: begin
          grp_o.tok[0] = mk_tok(wkind, start_q, len_q, line_q);
          n = CNT_W'(1);
        end
        default: ;
      endcase
      mode_d = MODE_IDLE;
      len_d  = '0;
      kw_d   = '0;
      pos_d  = pos_t'(pos_q + pos_t'(1));

      // Start of a new lexeme, or a single-byte outcome
      if (ch_i == CH_EOT) begin
        pos_d  = '0;
        line_d = fld_t'(1);
      end else if (ch_i == CH_LF) begin
        if (line_q != FLD_MAX) line_d = fld_t'(line_q + fld_t'(1));
      end else if (ch_i == CH_SP || ch_i == CH_CR || ch_i == CH_TAB) begin
        // whitespace
      end else if (is_digit(ch_i)) begin
        mode_d  = MODE_INT;
        start_d = pos_q;
        len_d   = fld_t'(1);
      end else if (is_letter(ch_i)) begin
        mode_d  = MODE_WORD;
        start_d = pos_q;
        len_d   = fld_t'(1);
        for (int unsigned k = 0; k < KW_NUM; k++) begin
          kw_d[k] = kw_char_ok(k, '0, ch_i);
        end
      end else begin
        grp_o.tok[n[IDX_W-1:0]] = mk_tok(KIND_ERR, pos_q, fld_t'(1), line_q);
        n = CNT_W'(n + CNT_W'(1));
      end
    end else begin
      pos_d = pos_t'(pos_q + pos_t'(1));
    end

    grp_o.cnt = n;
  end

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      line_q  <= fld_t'(1);
      kw_q    <= '0;
    end else if (adv_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      line_q  <= line_d;
      kw_q    <= kw_d;
    end
  end

endmodule

>>> rtl/ats_tok_buf.sv
module ats_tok_buf
  import ats_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  tok_grp_t    grp_i,
  output logic        free_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // token_start, token_length, token_line
  output logic [2:0]  m_axis_tuser_o,   // token_kind
  output logic        m_axis_tlast_o    // is_last
);

  tok_grp_t         grp_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] rd_q;
  tok_t             head;
  logic             pop;

  assign head   = grp_q.tok[rd_q];
  assign pop    = m_axis_tvalid_o && m_axis_tready_i;
  // A new group may enter once the last token held is leaving
  assign free_o = (cnt_q == '0) || (cnt_q == CNT_W'(1) && m_axis_tready_i);

  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = {head.line, head.length, head.start};
  assign m_axis_tuser_o  = head.kind;
  assign m_axis_tlast_o  = (cnt_q == CNT_W'(1));

  // Token payload
  always_ff @(posedge clk_i) begin
    if (load_i && grp_i.cnt != '0) grp_q <= grp_i;
  end

  // Remaining count and read slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (load_i && grp_i.cnt != '0) begin
      cnt_q <= grp_i.cnt;
      rd_q  <= '0;
    end else if (pop) begin
      cnt_q <= CNT_W'(cnt_q - CNT_W'(1));
      rd_q  <= IDX_W'(rd_q + IDX_W'(1));
    end
  end

endmodule

>>> rtl/assembly_token_scanner_top.sv
// Streaming scanner for assembly source text. Bytes enter on the slave
// stream one per cycle unless stalled; byte 0 ends a text and resets the
// offset and line counters for the next one. Each byte is held in an input
// register, scanned by combinational logic, and the zero to three tokens it
// causes are registered in a token buffer that presents them one per cycle
// while the master stream is ready, tlast marking the last token of that
// byte. The buffer takes a new byte's tokens once its last token is leaving,
// so the input takes one byte per cycle as long as each byte causes at most
// one token and the master stream is ready, and stalls otherwise; a byte
// that causes no token passes even while the buffer is busy. Token offsets
// wrap at 2^16; lengths and line numbers saturate at 65535.
module assembly_token_scanner_top
  import ats_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // ch
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // token_start, token_length, token_line
  output logic [2:0]  m_axis_tuser_o,   // token_kind
  output logic        m_axis_tlast_o    // is_last
);

  logic [7:0] ch_q;
  logic       vld_q;
  logic       adv;
  logic       free;
  tok_grp_t   grp;

  // Scan the held byte when its tokens have room
  assign adv             = vld_q && (grp.cnt == '0 || free);
  assign s_axis_tready_o = !vld_q || adv;

  // Input register
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) ch_q <= s_axis_tdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      vld_q <= s_axis_tvalid_i;
    end
  end

  ats_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ch_i   (ch_q),
    .adv_i  (adv),
    .grp_o  (grp)
  );

  ats_tok_buf u_tok_buf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (adv),
    .grp_i           (grp),
    .free_o          (free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
